// ===== hdl/sscc_pkg.sv =====
package sscc_pkg;

   // field widths
   localparam int unsigned THROTTLE_W = 7;
   localparam int unsigned READING_W  = 12;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned DUTY_W     = 16;
   localparam int unsigned STEP_W     = 3;
   localparam int unsigned NUM_PHASES = 3;
   localparam int unsigned PRODUCT_W  = THROTTLE_W + DUTY_W;

   // configuration port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   // stream widths
   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 56;

   // throttle scale
   localparam logic [THROTTLE_W-1:0] FULL_PERCENT = 7'd100;

   // divide by 100 as multiply by ceil(2^30 / 100), exact for products below 2^23
   localparam int unsigned DIV_SHIFT   = 30;
   localparam int unsigned DIV_RECIP_W = 24;
   localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 24'd10737419;
   localparam int unsigned DIV_PROD_W  = PRODUCT_W + DIV_RECIP_W;

   // last commutation step
   localparam logic [STEP_W-1:0] LAST_STEP = 3'd5;

   // register reset values
   localparam logic [15:0] PERIOD_COUNTS_RST = 16'd1000;
   localparam logic [15:0] MIN_DUTY_RST      = 16'd40;
   localparam logic [6:0]  OFF_PERCENT_RST   = 7'd5;
   localparam logic [15:0] STEP_INTERVAL_RST = 16'd4;
   localparam logic [11:0] CURRENT_TRIP_RST  = 12'd3800;
   localparam logic [11:0] BEMF_TRIP_RST     = 12'd3900;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PERIOD_COUNTS = 3'd0,
      REG_MIN_DUTY      = 3'd1,
      REG_OFF_PERCENT   = 3'd2,
      REG_STEP_INTERVAL = 3'd3,
      REG_CURRENT_TRIP  = 3'd4,
      REG_BEMF_TRIP     = 3'd5
   } reg_index_type;

   typedef logic [1:0] phase_idx_type;

   localparam phase_idx_type PHASE_A = 2'd0;
   localparam phase_idx_type PHASE_B = 2'd1;
   localparam phase_idx_type PHASE_C = 2'd2;

   typedef struct packed {
      logic [DUTY_W-1:0]     period_counts;
      logic [DUTY_W-1:0]     min_duty;
      logic [THROTTLE_W-1:0] off_percent;
      logic [15:0]           step_interval_ms;
      logic [READING_W-1:0]  current_trip;
      logic [READING_W-1:0]  bemf_trip;
   } cfg_type;

   // one scaled request handed from the scale pipeline to the state logic
   typedef struct packed {
      logic              valid;
      logic [DUTY_W-1:0] duty;
      logic              running;
      logic              trip;
      logic [TIME_W-1:0] now_ms;
   } scaled_type;

   // high-side phase for each step
   function automatic phase_idx_type step_high(input logic [STEP_W-1:0] step);
      phase_idx_type res;
      case (step)
         3'd0, 3'd1: res = PHASE_A;
         3'd2, 3'd3: res = PHASE_B;
         3'd4, 3'd5: res = PHASE_C;
         default:    res = PHASE_A;
      endcase
      return res;
   endfunction

   // low-side phase for each step
   function automatic phase_idx_type step_low(input logic [STEP_W-1:0] step);
      phase_idx_type res;
      case (step)
         3'd0:       res = PHASE_B;
         3'd1, 3'd2: res = PHASE_C;
         3'd3, 3'd4: res = PHASE_A;
         3'd5:       res = PHASE_B;
         default:    res = PHASE_B;
      endcase
      return res;
   endfunction

endpackage

// ===== hdl/sscc_scale.sv =====
module sscc_scale (
   input  logic                           clock,
   input  logic                           reset,
   input  sscc_pkg::cfg_type              cfg,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [sscc_pkg::THROTTLE_W-1:0] in_throttle,
   input  logic [sscc_pkg::READING_W-1:0]  in_current,
   input  logic [sscc_pkg::READING_W-1:0]  in_bemf,
   input  logic [sscc_pkg::TIME_W-1:0]     in_now_ms,
   output sscc_pkg::scaled_type           out_item,
   input  logic                           out_ready
);

   // stage a: captured request
   logic                            a_valid_ff;
   logic [sscc_pkg::THROTTLE_W-1:0] a_throttle_ff;
   logic [sscc_pkg::READING_W-1:0]  a_current_ff;
   logic [sscc_pkg::READING_W-1:0]  a_bemf_ff;
   logic [sscc_pkg::TIME_W-1:0]     a_now_ff;

   // stage b: throttle times period
   logic                            b_valid_ff;
   logic [sscc_pkg::PRODUCT_W-1:0]  b_product_ff;
   logic                            b_running_ff;
   logic                            b_trip_ff;
   logic [sscc_pkg::TIME_W-1:0]     b_now_ff;

   // stage c: duty after divide by 100
   logic                            c_valid_ff;
   logic [sscc_pkg::DUTY_W-1:0]     c_duty_ff;
   logic                            c_running_ff;
   logic                            c_trip_ff;
   logic [sscc_pkg::TIME_W-1:0]     c_now_ff;

   logic                            a_ready;
   logic                            b_ready;
   logic                            c_ready;
   logic [sscc_pkg::THROTTLE_W-1:0] thr_clamped;
   logic [sscc_pkg::PRODUCT_W-1:0]  product;
   logic [sscc_pkg::DIV_PROD_W-1:0] recip_product;

   // stage handshakes, a stage takes data when empty or draining
   assign c_ready  = !c_valid_ff || out_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // throttle clamp and scale
   assign thr_clamped = (a_throttle_ff > sscc_pkg::FULL_PERCENT) ?
                        sscc_pkg::FULL_PERCENT : a_throttle_ff;
   assign product = sscc_pkg::PRODUCT_W'(thr_clamped) *
                    sscc_pkg::PRODUCT_W'(cfg.period_counts);

   // reciprocal multiply for the divide
   assign recip_product = sscc_pkg::DIV_PROD_W'(b_product_ff) *
                          sscc_pkg::DIV_PROD_W'(sscc_pkg::DIV_RECIP);

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (c_ready) c_valid_ff <= b_valid_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_throttle_ff <= in_throttle;
         a_current_ff  <= in_current;
         a_bemf_ff     <= in_bemf;
         a_now_ff      <= in_now_ms;
      end
      if (b_ready && a_valid_ff) begin
         b_product_ff <= product;
         b_running_ff <= thr_clamped > cfg.off_percent;
         b_trip_ff    <= (a_current_ff > cfg.current_trip) || (a_bemf_ff > cfg.bemf_trip);
         b_now_ff     <= a_now_ff;
      end
      if (c_ready && b_valid_ff) begin
         c_duty_ff    <= recip_product[sscc_pkg::DIV_SHIFT +: sscc_pkg::DUTY_W];
         c_running_ff <= b_running_ff;
         c_trip_ff    <= b_trip_ff;
         c_now_ff     <= b_now_ff;
      end
   end

   assign out_item.valid   = c_valid_ff;
   assign out_item.duty    = c_duty_ff;
   assign out_item.running = c_running_ff;
   assign out_item.trip    = c_trip_ff;
   assign out_item.now_ms  = c_now_ff;

endmodule

// ===== hdl/six_step_commutation_controller.sv =====
// channel  direction  handshake             payload
// req      in         req_tvalid/tready     throttle, current, back-EMF, time
// rsp      out        rsp_tvalid/tready     three phase duties, low sides, step
// csr      in         csr_we (no wait)      six config registers by index
//
// a request passes three scale stages (capture, throttle x period multiply,
// reciprocal multiply for the divide by 100), then combinational step and
// drive logic loads the result register. one request per cycle is sustained
// while rsp_tready holds; the step and drive state loads with the result.
// reset clears the commutation state (phases off, step 0), loads config
// defaults. a stalled rsp holds its result; earlier stages fill behind it.
module six_step_commutation_controller (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // throttle_percent[6:0], current_reading[18:7], bemf_reading[30:19],
   // now_ms[62:31], zero [63]
   input  logic [sscc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // duty_phase_a[15:0], duty_phase_b[31:16], duty_phase_c[47:32],
   // low_on_a[48], low_on_b[49], low_on_c[50], step_now[53:51], zero [55:54]
   output logic [sscc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // configuration writes
   input  logic                               csr_we,
   input  logic [sscc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sscc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   sscc_pkg::cfg_type               cfg_ff;
   sscc_pkg::scaled_type            scaled;
   logic                            scaled_ready;
   logic                            take;

   // commutation state; step, phase duties and low sides are also the result payload
   logic [sscc_pkg::STEP_W-1:0]     comm_step_ff,  comm_step_in;
   logic [sscc_pkg::TIME_W-1:0]     last_time_ff,  last_time_in;
   logic [sscc_pkg::DUTY_W-1:0]     last_duty_ff,  last_duty_in;
   logic [sscc_pkg::DUTY_W-1:0]     phase_duty_ff [sscc_pkg::NUM_PHASES];
   logic [sscc_pkg::DUTY_W-1:0]     phase_duty_in [sscc_pkg::NUM_PHASES];
   logic [sscc_pkg::NUM_PHASES-1:0] low_on_ff,     low_on_in;
   logic                            rsp_valid_ff;

   logic [sscc_pkg::TIME_W-1:0]     elapsed;
   logic                            step_event;
   logic                            advanced;
   logic [sscc_pkg::STEP_W-1:0]     step_next;
   logic [sscc_pkg::DUTY_W-1:0]     clamped;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_counts    <= sscc_pkg::PERIOD_COUNTS_RST;
         cfg_ff.min_duty         <= sscc_pkg::MIN_DUTY_RST;
         cfg_ff.off_percent      <= sscc_pkg::OFF_PERCENT_RST;
         cfg_ff.step_interval_ms <= sscc_pkg::STEP_INTERVAL_RST;
         cfg_ff.current_trip     <= sscc_pkg::CURRENT_TRIP_RST;
         cfg_ff.bemf_trip        <= sscc_pkg::BEMF_TRIP_RST;
      end else if (csr_we) begin
         case (csr_index)
            sscc_pkg::REG_PERIOD_COUNTS: cfg_ff.period_counts    <= csr_wdata;
            sscc_pkg::REG_MIN_DUTY:      cfg_ff.min_duty         <= csr_wdata;
            sscc_pkg::REG_OFF_PERCENT:   cfg_ff.off_percent      <= csr_wdata[6:0];
            sscc_pkg::REG_STEP_INTERVAL: cfg_ff.step_interval_ms <= csr_wdata;
            sscc_pkg::REG_CURRENT_TRIP:  cfg_ff.current_trip     <= csr_wdata[11:0];
            sscc_pkg::REG_BEMF_TRIP:     cfg_ff.bemf_trip        <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // duty scale pipeline
   sscc_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_throttle (req_tdata[6:0]),
      .in_current  (req_tdata[18:7]),
      .in_bemf     (req_tdata[30:19]),
      .in_now_ms   (req_tdata[62:31]),
      .out_item    (scaled),
      .out_ready   (scaled_ready)
   );

   assign scaled_ready = !rsp_valid_ff || rsp_tready;
   assign take         = scaled.valid && scaled_ready;

   // step timing
   assign elapsed    = scaled.now_ms - last_time_ff;
   assign step_event = elapsed > sscc_pkg::TIME_W'(cfg_ff.step_interval_ms);
   assign step_next  = (comm_step_ff >= sscc_pkg::LAST_STEP) ? '0 : comm_step_ff + 3'd1;
   assign advanced   = step_event && scaled.running;
   assign clamped    = (scaled.duty > cfg_ff.period_counts) ?
                       cfg_ff.period_counts : scaled.duty;

   // step and drive update for one request
   always_comb begin
      comm_step_in = comm_step_ff;
      last_time_in = last_time_ff;
      last_duty_in = last_duty_ff;
      low_on_in    = low_on_ff;
      for (int p = 0; p < sscc_pkg::NUM_PHASES; p++) begin
         phase_duty_in[p] = phase_duty_ff[p];
      end

      if (step_event) begin
         last_time_in = scaled.now_ms;
         comm_step_in = scaled.running ? step_next : '0;
      end

      if (!scaled.running) begin
         for (int p = 0; p < sscc_pkg::NUM_PHASES; p++) begin
            phase_duty_in[p] = '0;
         end
         low_on_in    = '0;
         last_duty_in = '0;
      end else begin
         // reapply drive on a duty change or a step advance, when duty is above min_duty
         if ((scaled.duty > cfg_ff.min_duty) &&
             ((scaled.duty != last_duty_ff) || advanced)) begin
            for (int p = 0; p < sscc_pkg::NUM_PHASES; p++) begin
               phase_duty_in[p] = '0;
            end
            low_on_in = '0;
            phase_duty_in[sscc_pkg::step_high(comm_step_in)] = clamped;
            low_on_in[sscc_pkg::step_low(comm_step_in)]      = 1'b1;
            last_duty_in = scaled.duty;
         end
         // overcurrent or back-EMF trip
         if (scaled.trip) begin
            for (int p = 0; p < sscc_pkg::NUM_PHASES; p++) begin
               phase_duty_in[p] = '0;
            end
            low_on_in    = '0;
            comm_step_in = '0;
         end
      end
   end

   // state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         comm_step_ff <= '0;
         last_time_ff <= '0;
         last_duty_ff <= '0;
         low_on_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < sscc_pkg::NUM_PHASES; p++) begin
            phase_duty_ff[p] <= '0;
         end
      end else begin
         if (take) begin
            comm_step_ff <= comm_step_in;
            last_time_ff <= last_time_in;
            last_duty_ff <= last_duty_in;
            low_on_ff    <= low_on_in;
            for (int p = 0; p < sscc_pkg::NUM_PHASES; p++) begin
               phase_duty_ff[p] <= phase_duty_in[p];
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, comm_step_ff, low_on_ff,
                        phase_duty_ff[sscc_pkg::PHASE_C],
                        phase_duty_ff[sscc_pkg::PHASE_B],
                        phase_duty_ff[sscc_pkg::PHASE_A]};

endmodule
